// ===== hdl/atvtok_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atvtok_pkg
// Shared types and constants of the attribute text tokenizer: lexer phases,
// result event and error codes, character codes and the queue record.
// ----------------------------------------------------------------------------
package atvtok_pkg;

	// reported line number width and queue depth
	localparam int LINE_NUM_W  = 16;
	localparam int QUEUE_DEPTH = 2;

	// lexer phases
	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_BARE  = 4'd1,
		PH_QUOTE = 4'd2,
		PH_ESC   = 4'd3,
		PH_SLASH = 4'd4,
		PH_LCOM  = 4'd5,
		PH_BCOM  = 4'd6,
		PH_BSTAR = 4'd7,
		PH_HEX1  = 4'd8,
		PH_HEX2  = 4'd9
	} lex_state_t;

	// result event codes
	typedef enum logic [2:0] {
		EV_CHAR  = 3'd0,
		EV_WEND  = 3'd1,
		EV_OPEN  = 3'd2,
		EV_CLOSE = 3'd3,
		EV_EQ    = 3'd4,
		EV_END   = 3'd5,
		EV_ERR   = 3'd6
	} event_code_t;

	// lexical error codes
	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_QUOTE   = 3'd1,
		ERR_COMMENT = 3'd2,
		ERR_HEX     = 3'd3,
		ERR_BLOCK   = 3'd4
	} err_code_t;

	// character codes
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_EQUALS = 8'h3d;
	localparam logic [7:0] CH_LOW_X  = 8'h78;
	localparam logic [7:0] CH_UP_X   = 8'h58;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;

	// one classified input item: one or two result beats
	typedef struct packed {
		logic                  two;
		event_code_t           ev0;
		logic [7:0]            ch0;
		err_code_t             err0;
		event_code_t           ev1;
		logic [LINE_NUM_W-1:0] line;
	} tok_rec_t;

endpackage

// ===== hdl/atvtok_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atvtok_front
// Lexer front end: takes one byte or end mark per beat, keeps the lexer phase,
// hex escape nibble and line counter, and pushes a record of the results.
// ----------------------------------------------------------------------------
module atvtok_front
	import atvtok_pkg::*;
#(
	parameter int LINE_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_in,
	input  logic       end_mark,
	input  logic       q_full,
	output logic       push,
	output tok_rec_t   rec
);

	lex_state_t           state_q, state_d;
	logic [3:0]           hex_high_q, hex_high_d;
	logic [LINE_BITS-1:0] line_q, line_d;
	logic [LINE_NUM_W-1:0] line_rep;
	logic                 accept;
	logic                 has_res;

	// idle handling of the current input
	logic                 idle_has;
	event_code_t          idle_ev;
	lex_state_t           idle_nxt;

	// hex digit decode
	logic                 hex_ok;
	logic [3:0]           hex_val;

	logic                 delim;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && has_res;

	// line count including this beat's newline, saturating
	always_comb begin
		line_d = line_q;
		if (!end_mark && byte_in == CH_LF && line_q != {LINE_BITS{1'b1}})
			line_d = line_q + 1'b1;
	end

	// report the line count in LINE_NUM_W bits: its low bits, or zero-extended
	generate
		if (LINE_BITS >= LINE_NUM_W) begin : g_line_trunc
			assign line_rep = line_d[LINE_NUM_W-1:0];
		end else begin : g_line_ext
			assign line_rep = {{(LINE_NUM_W-LINE_BITS){1'b0}}, line_d};
		end
	endgenerate

	// hex digit value
	always_comb begin
		hex_ok  = 1'b0;
		hex_val = 4'd0;
		if (!end_mark) begin
			if (byte_in >= CH_0 && byte_in <= CH_9) begin
				hex_ok  = 1'b1;
				hex_val = 4'(byte_in - CH_0);
			end else if (byte_in >= CH_LOW_A && byte_in <= CH_LOW_F) begin
				hex_ok  = 1'b1;
				hex_val = 4'(byte_in - CH_LOW_A + 8'd10);
			end else if (byte_in >= CH_UP_A && byte_in <= CH_UP_F) begin
				hex_ok  = 1'b1;
				hex_val = 4'(byte_in - CH_UP_A + 8'd10);
			end
		end
	end

	// what the idle phase does with this input
	always_comb begin
		idle_has = 1'b0;
		idle_ev  = EV_END;
		idle_nxt = PH_IDLE;
		if (end_mark) begin
			idle_has = 1'b1;
			idle_ev  = EV_END;
		end else begin
			unique case (byte_in) inside
				CH_SP, CH_TAB, CH_CR, CH_LF: idle_has = 1'b0;
				CH_DQUOTE: idle_nxt = PH_QUOTE;
				CH_SLASH:  idle_nxt = PH_SLASH;
				CH_LBRACE: begin
					idle_has = 1'b1;
					idle_ev  = EV_OPEN;
				end
				CH_RBRACE: begin
					idle_has = 1'b1;
					idle_ev  = EV_CLOSE;
				end
				CH_EQUALS: begin
					idle_has = 1'b1;
					idle_ev  = EV_EQ;
				end
				default: begin
					idle_has = 1'b1;
					idle_ev  = EV_CHAR;
					idle_nxt = PH_BARE;
				end
			endcase
		end
	end

	// bytes, and the end mark, that end a bare word
	always_comb begin
		delim = end_mark;
		if (!end_mark) begin
			case (byte_in) inside
				CH_SP, CH_TAB, CH_CR, CH_LF, CH_LBRACE, CH_RBRACE, CH_EQUALS, CH_SLASH:
					delim = 1'b1;
				default: delim = 1'b0;
			endcase
		end
	end

	// lexer next phase and result record
	always_comb begin
		state_d    = state_q;
		hex_high_d = hex_high_q;
		has_res    = 1'b0;
		rec.two    = 1'b0;
		rec.ev0    = EV_CHAR;
		rec.ch0    = 8'd0;
		rec.err0   = ERR_NONE;
		rec.ev1    = EV_END;
		rec.line   = line_rep;
		unique case (state_q)
			PH_BARE: begin
				has_res = 1'b1;
				if (delim) begin
					rec.ev0 = EV_WEND;
					rec.two = idle_has;
					rec.ev1 = idle_ev;
					state_d = idle_nxt;
				end else begin
					rec.ch0 = byte_in;
				end
			end
			PH_QUOTE: begin
				if (end_mark) begin
					has_res  = 1'b1;
					rec.ev0  = EV_ERR;
					rec.err0 = ERR_QUOTE;
					state_d  = PH_IDLE;
				end else if (byte_in == CH_DQUOTE) begin
					has_res = 1'b1;
					rec.ev0 = EV_WEND;
					state_d = PH_IDLE;
				end else if (byte_in == CH_BSLASH) begin
					state_d = PH_ESC;
				end else begin
					has_res = 1'b1;
					rec.ch0 = byte_in;
				end
			end
			PH_ESC: begin
				if (end_mark) begin
					has_res  = 1'b1;
					rec.ev0  = EV_ERR;
					rec.err0 = ERR_QUOTE;
					state_d  = PH_IDLE;
				end else if (byte_in == CH_LOW_X || byte_in == CH_UP_X) begin
					hex_high_d = 4'd0;
					state_d    = PH_HEX1;
				end else begin
					has_res = 1'b1;
					rec.ch0 = byte_in;
					state_d = PH_QUOTE;
				end
			end
			PH_HEX1: begin
				if (!hex_ok) begin
					has_res  = 1'b1;
					rec.ev0  = EV_ERR;
					rec.err0 = ERR_HEX;
					state_d  = PH_IDLE;
				end else begin
					hex_high_d = hex_val;
					state_d    = PH_HEX2;
				end
			end
			PH_HEX2: begin
				has_res = 1'b1;
				if (!hex_ok) begin
					rec.ev0  = EV_ERR;
					rec.err0 = ERR_HEX;
					state_d  = PH_IDLE;
				end else begin
					rec.ch0 = {hex_high_q, hex_val};
					state_d = PH_QUOTE;
				end
			end
			PH_SLASH: begin
				if (!end_mark && byte_in == CH_SLASH) begin
					state_d = PH_LCOM;
				end else if (!end_mark && byte_in == CH_STAR) begin
					state_d = PH_BCOM;
				end else begin
					has_res  = 1'b1;
					rec.ev0  = EV_ERR;
					rec.err0 = ERR_COMMENT;
					state_d  = PH_IDLE;
				end
			end
			PH_LCOM: begin
				if (end_mark) begin
					has_res = 1'b1;
					rec.ev0 = EV_END;
					state_d = PH_IDLE;
				end else if (byte_in == CH_LF) begin
					state_d = PH_IDLE;
				end
			end
			PH_BCOM: begin
				if (end_mark) begin
					has_res  = 1'b1;
					rec.ev0  = EV_ERR;
					rec.err0 = ERR_BLOCK;
					state_d  = PH_IDLE;
				end else if (byte_in == CH_STAR) begin
					state_d = PH_BSTAR;
				end
			end
			PH_BSTAR: begin
				if (end_mark) begin
					has_res  = 1'b1;
					rec.ev0  = EV_ERR;
					rec.err0 = ERR_BLOCK;
					state_d  = PH_IDLE;
				end else if (byte_in == CH_SLASH) begin
					state_d = PH_IDLE;
				end else begin
					state_d = PH_BCOM;
				end
			end
			default: begin
				has_res = idle_has;
				rec.ev0 = idle_ev;
				rec.ch0 = (idle_ev == EV_CHAR) ? byte_in : 8'd0;
				state_d = idle_nxt;
			end
		endcase
	end

	// lexer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= PH_IDLE;
			hex_high_q <= 4'd0;
			line_q     <= {{(LINE_BITS-1){1'b0}}, 1'b1};
		end else if (accept) begin
			state_q    <= state_d;
			hex_high_q <= hex_high_d;
			line_q     <= line_d;
		end
	end

endmodule

// ===== hdl/atvtok_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atvtok_queue
// Short record queue between the lexer front end and the result back end.
// ----------------------------------------------------------------------------
module atvtok_queue
	import atvtok_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  tok_rec_t wr_rec,
	input  logic     pop,
	output tok_rec_t rd_rec,
	output logic     not_empty,
	output logic     full
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	tok_rec_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_rec    = mem_q[rd_ptr_q];

	// record storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_rec;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== hdl/atvtok_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atvtok_back
// Result back end: expands each queued record into one or two result beats
// and holds them in the output register until taken.
// ----------------------------------------------------------------------------
module atvtok_back
	import atvtok_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  tok_rec_t              rec,
	input  logic                  rec_valid,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            event_res,
	output logic [7:0]            char_out,
	output logic [2:0]            error_code,
	output logic [LINE_NUM_W-1:0] line_number,
	output logic                  last
);

	logic                  out_valid_q;
	logic                  pend_q;
	event_code_t           ev_q;
	logic [7:0]            ch_q;
	err_code_t             err_q;
	logic [LINE_NUM_W-1:0] line_q;
	logic                  last_q;
	event_code_t           pend_ev_q;
	logic [LINE_NUM_W-1:0] pend_line_q;
	logic                  load;

	assign load = !out_valid_q || out_ready;
	assign pop  = load && !pend_q && rec_valid;

	assign out_valid   = out_valid_q;
	assign event_res   = ev_q;
	assign char_out    = ch_q;
	assign error_code  = err_q;
	assign line_number = line_q;
	assign last        = last_q;

	// output valid and pending second beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (rec_valid) begin
				out_valid_q <= 1'b1;
				pend_q      <= rec.two;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				ev_q   <= pend_ev_q;
				ch_q   <= 8'd0;
				err_q  <= ERR_NONE;
				line_q <= pend_line_q;
				last_q <= 1'b1;
			end else if (rec_valid) begin
				ev_q        <= rec.ev0;
				ch_q        <= rec.ch0;
				err_q       <= rec.err0;
				line_q      <= rec.line;
				last_q      <= !rec.two;
				pend_ev_q   <= rec.ev1;
				pend_line_q <= rec.line;
			end
		end
	end

endmodule

// ===== hdl/atv_text_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atv_text_tokenizer
// Streaming tokenizer for brace-structured attribute text, one byte per beat.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock as long as its two-record queue
// has room. Each byte or end mark is classified by the lexer in the cycle it
// is accepted, and its record is written to the queue at the accepting edge.
// The first result is loaded into the output register at the next clock edge
// when that register is free. Most beats give zero or one result. A brace,
// equals or end mark that ends a bare word gives two results, which leave
// the output register one after the other; the output side drains one result
// per cycle while out_ready is high, so a run of such beats is limited by the
// output register and the input stalls once the queue fills.
// The line counter is LINE_BITS wide, saturates, and is reported in 16 bits.
module atv_text_tokenizer
	import atvtok_pkg::*;
#(
	parameter int LINE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            byte_in,
	input  logic                  end_mark,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            event_res,
	output logic [7:0]            char_out,
	output logic [2:0]            error_code,
	output logic [LINE_NUM_W-1:0] line_number,
	output logic                  last
);

	tok_rec_t wr_rec, rd_rec;
	logic     push, pop, q_full, q_not_empty;

	// lexer front end
	atvtok_front #(
		.LINE_BITS(LINE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.byte_in  (byte_in),
		.end_mark (end_mark),
		.q_full   (q_full),
		.push     (push),
		.rec      (wr_rec)
	);

	// record queue
	atvtok_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_rec    (wr_rec),
		.pop       (pop),
		.rd_rec    (rd_rec),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	// result back end
	atvtok_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec         (rd_rec),
		.rec_valid   (q_not_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_res   (event_res),
		.char_out    (char_out),
		.error_code  (error_code),
		.line_number (line_number),
		.last        (last)
	);

`ifndef ASSERT_OFF
	// an error beat always closes its input's results
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_ERR |-> last)
		else $error("error beat not marked last");

	// error code present exactly on error beats
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((event_res == EV_ERR) == (error_code != ERR_NONE)))
		else $error("error code does not match event");

	// a second beat is always a single-character token or end of input
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && last &&
		(event_res == EV_OPEN || event_res == EV_CLOSE ||
		 event_res == EV_EQ || event_res == EV_END))
		else $error("bad second result beat");

	// a non-character beat carries no character
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_CHAR |-> char_out == 8'd0)
		else $error("character on non-character beat");
`endif

endmodule
